>>> hdl/sorted_name_table_prefix_search_defines.svh
// Assertion macros for the sorted name table prefix search block.
// Included by the modules that carry assertions; no other dependencies.
`ifndef SORTED_NAME_TABLE_PREFIX_SEARCH_DEFINES_SVH
`define SORTED_NAME_TABLE_PREFIX_SEARCH_DEFINES_SVH
`ifndef SYNTH
`define SNTPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SNTPS_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SNTPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SNTPS_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/sntps_pkg.sv
// Package: sizes, codes and controller/datapath interface types.
// Used by sntps_ctrl, sntps_dp and the top level.
package sntps_pkg;
	localparam int MAX_ENTRIES    = 4096;
	localparam int MAX_NAME_CHARS = 32;
	localparam int ENTRY_W = $clog2(MAX_ENTRIES);
	localparam int POS_W   = $clog2(MAX_NAME_CHARS);
	localparam int ADDR_W  = ENTRY_W + POS_W;
	localparam int COUNT_W = ENTRY_W + 1;
	localparam int LEN_W   = $clog2(MAX_NAME_CHARS + 2);
	localparam int CHAR_W  = 16;
	localparam logic [CHAR_W-1:0] SEMI_CHAR = 16'h003B;

	typedef enum logic [1:0] {
		CMD_LOAD_CHAR = 2'd0,
		CMD_LOAD_LEN  = 2'd1,
		CMD_START     = 2'd2,
		CMD_ADVANCE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CMP_BEFORE = 2'd0,
		CMP_PREFIX = 2'd1,
		CMP_AFTER  = 2'd2
	} cmp_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD_CHAR, OP_LOAD_LEN, OP_START, OP_ADV_INIT,
		OP_RD_F, OP_RD_L, OP_RD_MID, OP_RD_FIRST,
		OP_FIRST_F, OP_FIRST_L, OP_F_MID, OP_L_MID, OP_UP_INIT,
		OP_LAST_L, OP_LAST_F, OP_FINISH
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LO_CHK, ST_LO_C1, ST_LO_LP, ST_LO_LC,
		ST_UP_INIT, ST_UP_CHK, ST_UP_C1, ST_UP_LP, ST_UP_LC,
		ST_FIN_RD, ST_FIN_C, ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic eq;       // f == l
		logic span_gt2; // l - f + 1 > 2
		cmp_t cmp;      // probe result on registered read data
		logic alive;
	} dp_stat_t;
endpackage

>>> hdl/sntps_dp.sv
// Datapath: name tables, search range registers, probe compare.
// Depends on sntps_pkg.
module sntps_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sntps_pkg::dp_cmd_t                  cmd_in,
	output sntps_pkg::dp_stat_t                 stat,
	input  logic [sntps_pkg::ENTRY_W-1:0]       entry_index,
	input  logic [sntps_pkg::POS_W-1:0]         char_pos,
	input  logic [sntps_pkg::CHAR_W-1:0]        char_value,
	input  logic [5:0]                          name_length,
	input  logic                                has_semicolon,
	input  logic                                cfg_wr_en,
	input  logic [12:0]                         cfg_wr_data,
	output logic                                still_prefix,
	output logic                                match_found,
	output logic [sntps_pkg::ENTRY_W-1:0]       match_index,
	output logic [sntps_pkg::LEN_W-1:0]         match_length,
	output logic [sntps_pkg::LEN_W-1:0]         depth
);
	localparam int EW = sntps_pkg::ENTRY_W;
	localparam int CW = sntps_pkg::COUNT_W;
	localparam int LW = sntps_pkg::LEN_W;

	logic [sntps_pkg::CHAR_W-1:0] chars_mem [sntps_pkg::MAX_ENTRIES*sntps_pkg::MAX_NAME_CHARS];
	logic [LW:0]                  lens_mem  [sntps_pkg::MAX_ENTRIES];

	logic [EW-1:0] f_q, l_q, first_q, last_q, midx_q;
	logic [LW-1:0] depth_q, mlen_q;
	logic          alive_q, mvalid_q;
	logic [CW-1:0] count_q;
	logic [sntps_pkg::CHAR_W-1:0] char_q, rd_char_q;
	logic [LW-1:0] rd_len_q;
	logic          rd_semi_q;

	logic [CW-1:0] span, mid_w;
	logic [EW-1:0] mid, rd_entry;
	logic [LW-1:0] ld_len, full, depth_inc;
	logic [sntps_pkg::CHAR_W-1:0] ec;
	logic          ec_valid;
	sntps_pkg::cmp_t cmp;

	assign span  = {1'b0, l_q} - {1'b0, f_q} + CW'(1);
	assign mid_w = {1'b0, f_q} + (span >> 1);
	assign mid   = mid_w[EW-1:0];
	assign ld_len = (LW'(name_length) > LW'(sntps_pkg::MAX_NAME_CHARS))
		? LW'(sntps_pkg::MAX_NAME_CHARS) : LW'(name_length);
	assign full      = rd_len_q + LW'(rd_semi_q);
	assign depth_inc = depth_q + LW'(1);

	always_comb begin
		unique case (cmd_in.op)
			sntps_pkg::OP_RD_F:   rd_entry = f_q;
			sntps_pkg::OP_RD_L:   rd_entry = l_q;
			sntps_pkg::OP_RD_MID: rd_entry = mid;
			default:              rd_entry = first_q;
		endcase
	end

	// probe: past the name end the semicolon, if any, stands as one more character
	always_comb begin
		ec_valid = 1'b1;
		ec = rd_char_q;
		if (rd_len_q < depth_inc) begin
			if (!rd_semi_q || rd_len_q < depth_q) ec_valid = 1'b0;
			ec = sntps_pkg::SEMI_CHAR;
		end
		if (!ec_valid) cmp = sntps_pkg::CMP_BEFORE;
		else if (ec == char_q) cmp = sntps_pkg::CMP_PREFIX;
		else if (ec < char_q) cmp = sntps_pkg::CMP_BEFORE;
		else cmp = sntps_pkg::CMP_AFTER;
	end

	always_ff @(posedge clk) begin
		if (cmd_in.op == sntps_pkg::OP_LOAD_CHAR)
			chars_mem[{entry_index, char_pos}] <= char_value;
		if (cmd_in.op == sntps_pkg::OP_LOAD_LEN)
			lens_mem[entry_index] <= {has_semicolon, ld_len};
		rd_char_q <= chars_mem[{rd_entry, depth_q[sntps_pkg::POS_W-1:0]}];
		{rd_semi_q, rd_len_q} <= lens_mem[rd_entry];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			last_q   <= EW'(sntps_pkg::MAX_ENTRIES - 1);
			depth_q  <= '0;
			alive_q  <= 1'b1;
			mvalid_q <= 1'b0;
			midx_q   <= '0;
			mlen_q   <= '0;
			count_q  <= CW'(sntps_pkg::MAX_ENTRIES);
			f_q      <= '0;
			l_q      <= '0;
			char_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_wr_data == '0) count_q <= CW'(1);
				else if (CW'(cfg_wr_data) > CW'(sntps_pkg::MAX_ENTRIES))
					count_q <= CW'(sntps_pkg::MAX_ENTRIES);
				else count_q <= CW'(cfg_wr_data);
			end
			case (cmd_in.op)
				sntps_pkg::OP_LOAD_LEN:
					if (entry_index == midx_q) mlen_q <= ld_len + LW'(has_semicolon);
				sntps_pkg::OP_START: begin
					first_q  <= '0;
					last_q   <= EW'(count_q - CW'(1));
					depth_q  <= '0;
					alive_q  <= 1'b1;
					mvalid_q <= 1'b0;
					midx_q   <= '0;
				end
				sntps_pkg::OP_ADV_INIT: begin
					f_q    <= first_q;
					l_q    <= last_q;
					char_q <= char_value;
				end
				sntps_pkg::OP_UP_INIT: begin
					f_q <= first_q;
					l_q <= last_q;
				end
				sntps_pkg::OP_FIRST_F: first_q <= f_q;
				sntps_pkg::OP_FIRST_L: first_q <= l_q;
				sntps_pkg::OP_F_MID:   f_q <= mid;
				sntps_pkg::OP_L_MID:   l_q <= mid;
				sntps_pkg::OP_LAST_L:  last_q <= l_q;
				sntps_pkg::OP_LAST_F:  last_q <= f_q;
				sntps_pkg::OP_FINISH: begin
					if (first_q == last_q && cmp != sntps_pkg::CMP_PREFIX) begin
						alive_q <= 1'b0;
					end else begin
						depth_q <= depth_inc;
						if (full == depth_inc) begin
							mvalid_q <= 1'b1;
							midx_q   <= first_q;
							mlen_q   <= full;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.eq       = (f_q == l_q);
	assign stat.span_gt2 = (span > CW'(2));
	assign stat.cmp      = cmp;
	assign stat.alive    = alive_q;

	assign still_prefix = alive_q;
	assign match_found  = mvalid_q;
	assign match_index  = mvalid_q ? midx_q : '0;
	assign match_length = mvalid_q ? mlen_q : '0;
	assign depth        = depth_q;
endmodule

>>> hdl/sntps_ctrl.sv
// Controller: sequences the two binary searches and the final probe.
// Depends on sntps_pkg and the assertion macro header.
`include "sorted_name_table_prefix_search_defines.svh"
module sntps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          cmd,
	input  sntps_pkg::dp_stat_t stat,
	output sntps_pkg::dp_cmd_t  cmd_out,
	output logic                busy,
	output logic                done
);
	sntps_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sntps_pkg::ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd_out.op = sntps_pkg::OP_NONE;
		unique case (state_q)
			sntps_pkg::ST_IDLE:
				if (start) begin
					state_nx = sntps_pkg::ST_DONE;
					unique case (sntps_pkg::cmd_t'(cmd))
						sntps_pkg::CMD_LOAD_CHAR: cmd_out.op = sntps_pkg::OP_LOAD_CHAR;
						sntps_pkg::CMD_LOAD_LEN:  cmd_out.op = sntps_pkg::OP_LOAD_LEN;
						sntps_pkg::CMD_START:     cmd_out.op = sntps_pkg::OP_START;
						default:
							if (stat.alive) begin
								cmd_out.op = sntps_pkg::OP_ADV_INIT;
								state_nx = sntps_pkg::ST_LO_CHK;
							end
					endcase
				end
			sntps_pkg::ST_LO_CHK:
				if (stat.eq) state_nx = sntps_pkg::ST_UP_INIT;
				else begin
					cmd_out.op = sntps_pkg::OP_RD_F;
					state_nx = sntps_pkg::ST_LO_C1;
				end
			sntps_pkg::ST_LO_C1: begin
				state_nx = sntps_pkg::ST_UP_INIT;
				if (stat.cmp == sntps_pkg::CMP_PREFIX) cmd_out.op = sntps_pkg::OP_FIRST_F;
				else if (stat.cmp == sntps_pkg::CMP_AFTER) cmd_out.op = sntps_pkg::OP_FIRST_L;
				else state_nx = sntps_pkg::ST_LO_LP;
			end
			sntps_pkg::ST_LO_LP:
				if (stat.span_gt2) begin
					cmd_out.op = sntps_pkg::OP_RD_MID;
					state_nx = sntps_pkg::ST_LO_LC;
				end else begin
					cmd_out.op = sntps_pkg::OP_FIRST_L;
					state_nx = sntps_pkg::ST_UP_INIT;
				end
			sntps_pkg::ST_LO_LC: begin
				cmd_out.op = (stat.cmp == sntps_pkg::CMP_BEFORE)
					? sntps_pkg::OP_F_MID : sntps_pkg::OP_L_MID;
				state_nx = sntps_pkg::ST_LO_LP;
			end
			sntps_pkg::ST_UP_INIT: begin
				cmd_out.op = sntps_pkg::OP_UP_INIT;
				state_nx = sntps_pkg::ST_UP_CHK;
			end
			sntps_pkg::ST_UP_CHK:
				if (stat.eq) state_nx = sntps_pkg::ST_FIN_RD;
				else begin
					cmd_out.op = sntps_pkg::OP_RD_L;
					state_nx = sntps_pkg::ST_UP_C1;
				end
			sntps_pkg::ST_UP_C1: begin
				state_nx = sntps_pkg::ST_FIN_RD;
				if (stat.cmp == sntps_pkg::CMP_PREFIX) cmd_out.op = sntps_pkg::OP_LAST_L;
				else if (stat.cmp == sntps_pkg::CMP_BEFORE) cmd_out.op = sntps_pkg::OP_LAST_F;
				else state_nx = sntps_pkg::ST_UP_LP;
			end
			sntps_pkg::ST_UP_LP:
				if (stat.span_gt2) begin
					cmd_out.op = sntps_pkg::OP_RD_MID;
					state_nx = sntps_pkg::ST_UP_LC;
				end else begin
					cmd_out.op = sntps_pkg::OP_LAST_F;
					state_nx = sntps_pkg::ST_FIN_RD;
				end
			sntps_pkg::ST_UP_LC: begin
				cmd_out.op = (stat.cmp == sntps_pkg::CMP_AFTER)
					? sntps_pkg::OP_L_MID : sntps_pkg::OP_F_MID;
				state_nx = sntps_pkg::ST_UP_LP;
			end
			sntps_pkg::ST_FIN_RD: begin
				cmd_out.op = sntps_pkg::OP_RD_FIRST;
				state_nx = sntps_pkg::ST_FIN_C;
			end
			sntps_pkg::ST_FIN_C: begin
				cmd_out.op = sntps_pkg::OP_FINISH;
				state_nx = sntps_pkg::ST_DONE;
			end
			sntps_pkg::ST_DONE: state_nx = sntps_pkg::ST_IDLE;
			default: state_nx = sntps_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != sntps_pkg::ST_IDLE);
	assign done = (state_q == sntps_pkg::ST_DONE);

	`SNTPS_ASSERT(a_done_single, clk, arst_n, done |=> !done, "result strobe held over two cycles")
	`SNTPS_ASSERT(a_done_busy, clk, arst_n, done |-> busy, "result strobe while idle")
	`SNTPS_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "transfer not followed by busy")
	`SNTPS_ASSERT(a_fin_done, clk, arst_n, (state_q == sntps_pkg::ST_FIN_C) |=> done, "final compare not followed by result")
endmodule

>>> hdl/sorted_name_table_prefix_search.sv
// Top level: incremental prefix search over a loaded sorted name table.
// Depends on sntps_pkg, sntps_ctrl and sntps_dp.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | cmd entry_index char_pos char_value
//           |                    | name_length has_semicolon
//  result   | done (1 cycle)     | still_prefix match_found match_index
//           |                    | match_length depth
//  config   | cfg_wr_en          | cfg_wr_data (entry count)
//
// Load, start and dead-advance commands strobe their result in the cycle after the transfer;
// the next transfer is taken once the block is back in idle.
// A live advance makes each table probe a read, then a compare on the registered read data;
// it runs the lower-edge search, the upper-edge search, then a read and compare of the first entry.
// Reset puts the search at the whole table with entry count 4096; the tables are not cleared.
// The result is shown for one cycle only; the receiver cannot stall it.
module sorted_name_table_prefix_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [sntps_pkg::ENTRY_W-1:0] entry_index,
	input  logic [sntps_pkg::POS_W-1:0]   char_pos,
	input  logic [sntps_pkg::CHAR_W-1:0]  char_value,
	input  logic [5:0]                    name_length,
	input  logic                          has_semicolon,
	input  logic                          cfg_wr_en,
	input  logic [12:0]                   cfg_wr_data,
	output logic                          done,
	output logic                          still_prefix,
	output logic                          match_found,
	output logic [sntps_pkg::ENTRY_W-1:0] match_index,
	output logic [sntps_pkg::LEN_W-1:0]   match_length,
	output logic [sntps_pkg::LEN_W-1:0]   depth
);
	sntps_pkg::dp_cmd_t  dp_cmd;
	sntps_pkg::dp_stat_t dp_stat;

	sntps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.stat    (dp_stat),
		.cmd_out (dp_cmd),
		.busy    (busy),
		.done    (done)
	);

	sntps_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_in        (dp_cmd),
		.stat          (dp_stat),
		.entry_index   (entry_index),
		.char_pos      (char_pos),
		.char_value    (char_value),
		.name_length   (name_length),
		.has_semicolon (has_semicolon),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.still_prefix  (still_prefix),
		.match_found   (match_found),
		.match_index   (match_index),
		.match_length  (match_length),
		.depth         (depth)
	);
endmodule

>>> dv/testbench.sv
// Testbench for sorted_name_table_prefix_search: loads small sorted name tables,
// runs prefix searches over them and checks every result against a built-in predictor.
// Depends on sntps_pkg and the top level only.
module testbench;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEM_TARGET = 1900;
	localparam int MAX_SLOTS   = 64;
	localparam int N_ENT = sntps_pkg::MAX_ENTRIES;
	localparam int N_CH  = sntps_pkg::MAX_NAME_CHARS;
	localparam int EW    = sntps_pkg::ENTRY_W;
	localparam int LW    = sntps_pkg::LEN_W;
	localparam int PW    = sntps_pkg::POS_W;
	localparam int CW    = sntps_pkg::CHAR_W;

	typedef struct packed {
		logic                alive;
		logic                found;
		logic [EW-1:0]       idx;
		logic [LW-1:0]       mlen;
		logic [LW-1:0]       dep;
	} search_result_t;

	class prefix_scoreboard;
		logic [CW-1:0]     chars[N_ENT*N_CH];
		logic [5:0]        lens[N_ENT];
		logic              semis[N_ENT];
		int                first, last, dep, midx, count;
		bit                alive, mvalid;
		search_result_t    expected_results[$];
		int                errors, checked, hit_count;

		function new();
			count = N_ENT;
			restart();
		endfunction

		function void restart();
			first = 0; last = count - 1; dep = 0;
			alive = 1; mvalid = 0; midx = 0;
		endfunction

		function void set_count(logic [12:0] v);
			count = (v == 0) ? 1 : (v > N_ENT) ? N_ENT : int'(v);
		endfunction

		function sntps_pkg::cmp_t probe(int e, logic [CW-1:0] c);
			logic [CW-1:0] ec;
			if (lens[e] < dep + 1) begin
				if (!semis[e] || lens[e] < dep)
					return sntps_pkg::CMP_BEFORE;
				ec = sntps_pkg::SEMI_CHAR;
			end else
				ec = chars[e*N_CH + dep];
			if (ec == c)
				return sntps_pkg::CMP_PREFIX;
			return (ec < c) ? sntps_pkg::CMP_BEFORE : sntps_pkg::CMP_AFTER;
		endfunction

		function int low_edge(int f, int l, logic [CW-1:0] c);
			sntps_pkg::cmp_t r;
			int m;
			if (f == l) return f;
			r = probe(f, c);
			if (r == sntps_pkg::CMP_PREFIX) return f;
			if (r == sntps_pkg::CMP_AFTER) return l;
			while (l - f + 1 > 2) begin
				m = f + (l - f + 1) / 2;
				if (probe(m, c) == sntps_pkg::CMP_BEFORE) f = m;
				else l = m;
			end
			return l;
		endfunction

		function int high_edge(int f, int l, logic [CW-1:0] c);
			sntps_pkg::cmp_t r;
			int m;
			if (f == l) return l;
			r = probe(l, c);
			if (r == sntps_pkg::CMP_PREFIX) return l;
			if (r == sntps_pkg::CMP_BEFORE) return f;
			while (l - f + 1 > 2) begin
				m = f + (l - f + 1) / 2;
				if (probe(m, c) == sntps_pkg::CMP_AFTER) l = m;
				else f = m;
			end
			return f;
		endfunction

		function void narrow(logic [CW-1:0] c);
			if (!alive) return;
			first = low_edge(first, last, c);
			last = high_edge(first, last, c);
			if (first == last && probe(first, c) != sntps_pkg::CMP_PREFIX) begin
				alive = 0;
				return;
			end
			dep++;
			if (lens[first] + semis[first] == dep) begin
				mvalid = 1;
				midx = first;
			end
		endfunction

		function void note_command(sntps_pkg::cmd_t c, int idx, int pos, logic [CW-1:0] ch,
				int len, bit semi);
			search_result_t r;
			case (c)
				sntps_pkg::CMD_LOAD_CHAR: chars[idx*N_CH + pos] = ch;
				sntps_pkg::CMD_LOAD_LEN: begin
					lens[idx] = 6'((len > N_CH) ? N_CH : len);
					semis[idx] = semi;
				end
				sntps_pkg::CMD_START: restart();
				default: narrow(ch);
			endcase
			r.alive = alive;
			r.found = mvalid;
			r.idx = EW'(mvalid ? midx : 0);
			r.mlen = mvalid ? LW'(lens[midx] + semis[midx]) : '0;
			r.dep = LW'(dep);
			expected_results.push_back(r);
		endfunction

		function void check_result(search_result_t got);
			search_result_t exp;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result with nothing outstanding: %p", got);
				return;
			end
			exp = expected_results.pop_front();
			checked++;
			if (got.found) hit_count++;
			if (got.alive !== exp.alive || got.found !== exp.found || got.idx !== exp.idx ||
					got.mlen !== exp.mlen || got.dep !== exp.dep) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp alive %0d found %0d idx %0d len %0d depth %0d, ",
						exp.alive, exp.found, exp.idx, exp.mlen, exp.dep,
						"got alive %0d found %0d idx %0d len %0d depth %0d",
						got.alive, got.found, got.idx, got.mlen, got.dep);
			end
		endfunction
	endclass

	logic                clk = 0;
	logic                arst_n = 0;
	logic                start = 0;
	logic                busy;
	logic [1:0]          cmd = sntps_pkg::CMD_START;
	logic [EW-1:0]       entry_index = 0;
	logic [PW-1:0]       char_pos = 0;
	logic [CW-1:0]       char_value = 0;
	logic [5:0]          name_length = 0;
	logic                has_semicolon = 0;
	logic                cfg_wr_en = 0;
	logic [12:0]         cfg_wr_data = 0;
	logic                done, still_prefix, match_found;
	logic [EW-1:0]       match_index;
	logic [LW-1:0]       match_length, depth;

	sorted_name_table_prefix_search i_dut (
		.clk, .arst_n, .start, .busy, .cmd, .entry_index, .char_pos, .char_value,
		.name_length, .has_semicolon, .cfg_wr_en, .cfg_wr_data, .done,
		.still_prefix, .match_found, .match_index, .match_length, .depth
	);

	prefix_scoreboard sb = new();

	// stimulus bookkeeping: which table cells hold known data
	bit                len_done[N_ENT];
	bit                char_done[N_ENT][N_CH];
	int                written_len[N_ENT];
	int                search_count = N_ENT;
	int                cfg_count = N_ENT;
	int                n_items, n_adv, n_tables, cycles;
	bit                idle_on, quiet;

	bit [CW-1:0]       nm[MAX_SLOTS][N_CH];
	int                nlen[MAX_SLOTS];
	bit                nsemi[MAX_SLOTS];

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		if (arst_n && done)
			sb.check_result('{still_prefix, match_found, match_index, match_length, depth});

	function automatic logic [CW-1:0] pick_char();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return sntps_pkg::SEMI_CHAR;
			4: return 16'h003A;
			5: return 16'h003C;
			6: return CW'($urandom());
			default: return CW'(16'h0061 + $urandom_range(0, 2));
		endcase
	endfunction

	// a search may only advance once the range fits the name slots and every entry in it is fully loaded
	function automatic bit table_safe();
		int e, p;
		if (search_count > MAX_SLOTS) return 0;
		for (e = 0; e < search_count; e++) begin
			if (!len_done[e]) return 0;
			for (p = 0; p < written_len[e]; p++)
				if (!char_done[e][p]) return 0;
		end
		return 1;
	endfunction

	task automatic send(sntps_pkg::cmd_t c, int idx, int pos, logic [CW-1:0] ch, int len,
			bit semi);
		bit b;
		if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		start <= 1;
		cmd <= c;
		entry_index <= EW'(idx);
		char_pos <= PW'(pos);
		char_value <= ch;
		name_length <= 6'(len);
		has_semicolon <= semi;
		forever begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
			if (!b) break;
		end
		sb.note_command(c, idx, pos, ch, len, semi);
		n_items++;
		case (c)
			sntps_pkg::CMD_LOAD_CHAR: char_done[idx][pos] = 1;
			sntps_pkg::CMD_LOAD_LEN: begin
				len_done[idx] = 1;
				written_len[idx] = (len > N_CH) ? N_CH : len;
			end
			sntps_pkg::CMD_START: search_count = cfg_count;
			default: n_adv++;
		endcase
	endtask

	task automatic drain();
		start <= 0;
		while (sb.expected_results.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(int v);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= 13'(v);
		@(posedge clk);
		cfg_wr_en <= 0;
		sb.set_count(13'(v));
		cfg_count = (v == 0) ? 1 : (v > N_ENT) ? N_ENT : v;
		@(posedge clk);
	endtask

	// key order: characters, then the semicolon if present, shorter first on a tie
	function automatic bit slot_after(int a, int b);
		int ka, kb, i;
		logic [CW-1:0] ca, cb;
		ka = nlen[a] + nsemi[a];
		kb = nlen[b] + nsemi[b];
		for (i = 0; i < ka && i < kb; i++) begin
			ca = (i < nlen[a]) ? nm[a][i] : sntps_pkg::SEMI_CHAR;
			cb = (i < nlen[b]) ? nm[b][i] : sntps_pkg::SEMI_CHAR;
			if (ca != cb) return ca > cb;
		end
		return ka > kb;
	endfunction

	task automatic build_table(int n);
		int i, j, p, l;
		bit s;
		logic [CW-1:0] tmp[N_CH];
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: nlen[i] = N_CH;
				1: nlen[i] = $urandom_range(0, N_CH);
				default: nlen[i] = $urandom_range(1, 6);
			endcase
			nsemi[i] = $urandom_range(0, 1);
			// shared prefixes keep the ranges wide for a few characters
			if (i > 0 && $urandom_range(0, 1))
				for (p = 0; p < N_CH; p++) nm[i][p] = nm[i-1][p];
			for (p = $urandom_range(0, 3); p < N_CH; p++) nm[i][p] = pick_char();
		end
		for (i = 1; i < n; i++)
			for (j = i; j > 0 && slot_after(j - 1, j); j--) begin
				for (p = 0; p < N_CH; p++) begin
					tmp[p] = nm[j][p]; nm[j][p] = nm[j-1][p]; nm[j-1][p] = tmp[p];
				end
				l = nlen[j]; nlen[j] = nlen[j-1]; nlen[j-1] = l;
				s = nsemi[j]; nsemi[j] = nsemi[j-1]; nsemi[j-1] = s;
			end
		for (i = 0; i < n; i++) begin
			for (p = 0; p < nlen[i]; p++)
				send(sntps_pkg::CMD_LOAD_CHAR, i, p, nm[i][p], $urandom_range(0, 63),
					$urandom_range(0, 1));
			l = nlen[i];
			if (l == N_CH && $urandom_range(0, 1)) l = $urandom_range(33, 63);
			send(sntps_pkg::CMD_LOAD_LEN, i, $urandom_range(0, 31), CW'($urandom()), l,
				nsemi[i]);
		end
		n_tables++;
	endtask

	task automatic load_noise();
		if ($urandom_range(0, 1))
			send(sntps_pkg::CMD_LOAD_CHAR, $urandom_range(MAX_SLOTS, N_ENT - 1),
				$urandom_range(0, 31), CW'($urandom()), $urandom_range(0, 63),
				$urandom_range(0, 1));
		else
			send(sntps_pkg::CMD_LOAD_LEN, $urandom_range(MAX_SLOTS, N_ENT - 1),
				$urandom_range(0, 31), CW'($urandom()), $urandom_range(0, 63),
				$urandom_range(0, 1));
	endtask

	task automatic run_search(int n);
		int t, p, klen;
		logic [CW-1:0] c;
		send(sntps_pkg::CMD_START, $urandom(), $urandom(), CW'($urandom()),
			$urandom_range(0, 63), $urandom_range(0, 1));
		if (!table_safe()) return;
		t = $urandom_range(0, n - 1);
		klen = nlen[t] + nsemi[t];
		for (p = 0; p <= klen; p++) begin
			if (p == klen || $urandom_range(0, 11) == 0) c = pick_char();
			else c = (p < nlen[t]) ? nm[t][p] : sntps_pkg::SEMI_CHAR;
			send(sntps_pkg::CMD_ADVANCE, $urandom(), $urandom(), c, $urandom_range(0, 63),
				$urandom_range(0, 1));
			if ($urandom_range(0, 19) == 0) load_noise();
			if ($urandom_range(0, 15) == 0) break;
		end
	endtask

	initial begin
		int n, k;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: one-entry table, semicolon match, depth limit, dead search, far index
		write_count(0);
		send(sntps_pkg::CMD_START, 0, 0, 0, 0, 0);
		send(sntps_pkg::CMD_LOAD_CHAR, N_ENT - 1, N_CH - 1, 16'hFFFF, 63, 1);
		send(sntps_pkg::CMD_LOAD_LEN, N_ENT - 1, 31, 16'hFFFF, 63, 1);
		send(sntps_pkg::CMD_LOAD_CHAR, 0, 0, 16'h0061, 0, 0);
		send(sntps_pkg::CMD_LOAD_LEN, 0, 0, 16'h0000, 1, 1);
		send(sntps_pkg::CMD_START, 0, 0, 0, 0, 0);
		send(sntps_pkg::CMD_ADVANCE, 0, 0, 16'h0061, 0, 0);
		send(sntps_pkg::CMD_ADVANCE, 0, 0, sntps_pkg::SEMI_CHAR, 0, 0);
		send(sntps_pkg::CMD_ADVANCE, 0, 0, sntps_pkg::SEMI_CHAR, 0, 0);
		send(sntps_pkg::CMD_ADVANCE, 0, 0, 16'h0061, 0, 0);
		send(sntps_pkg::CMD_START, 0, 0, 0, 0, 0);
		send(sntps_pkg::CMD_ADVANCE, 0, 0, 16'h0000, 0, 0);
		send(sntps_pkg::CMD_LOAD_LEN, 1, 0, 16'h0000, 0, 0);
		write_count(2);
		send(sntps_pkg::CMD_START, 0, 0, 0, 0, 0);
		send(sntps_pkg::CMD_ADVANCE, 0, 0, 16'hFFFF, 0, 0);
		// last entry shares the first character, so only both ends are probed
		send(sntps_pkg::CMD_LOAD_CHAR, N_ENT - 1, 0, 16'h0061, 0, 0);
		write_count(8191);
		send(sntps_pkg::CMD_START, 0, 0, 0, 0, 0);
		send(sntps_pkg::CMD_ADVANCE, 0, 0, 16'h0061, 0, 0);
		write_count(N_ENT);
		send(sntps_pkg::CMD_START, 0, 0, 0, 0, 0);

		while (n_items < ITEM_TARGET) begin
			quiet = (n_items > ITEM_TARGET - 250);
			idle_on = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 9))
				0: n = 1;
				1: n = $urandom_range(20, 40);
				default: n = $urandom_range(2, 12);
			endcase
			write_count((n == 1 && $urandom_range(0, 1)) ? 0 : n);
			build_table(n);
			for (k = $urandom_range(4, 10); k > 0; k--) run_search(n);
		end
		drain();
		write_count(N_ENT);
		send(sntps_pkg::CMD_START, 0, 0, 0, 0, 0);
		drain();
		repeat (64) @(posedge clk);

		$display("%0d commands (%0d advances) over %0d tables, ",
			n_items, n_adv, n_tables,
			"%0d results checked, %0d with a match", sb.checked, sb.hit_count);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("TB_OK");
		else begin
			$display("%0d mismatches, %0d results missing", sb.errors,
				sb.expected_results.size());
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

>>> filelist.f
+incdir+hdl
hdl/sntps_pkg.sv
hdl/sntps_dp.sv
hdl/sntps_ctrl.sv
hdl/sorted_name_table_prefix_search.sv
dv/testbench.sv
